FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// Check an implication, consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/sdf_pkg.sv
package sdf_pkg;

  // Frame limits and framing bytes
  localparam int unsigned MAX_FRAME  = 64;
  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [7:0]  END_BYTE   = 8'hFF;
  localparam logic [7:0]  LEN_EXTRA  = 8'd5;

  // Derived widths: index into one frame, byte count, compare width
  localparam int unsigned IDX_W  = $clog2(MAX_FRAME);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMP_W  = 9;

  // Frame store holds two frames: one being filled, one being drained
  localparam int unsigned RAM_AW    = IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** RAM_AW;

  // Result status codes
  localparam logic [1:0] STAT_FRAME = 2'd0;
  localparam logic [1:0] STAT_CSUM  = 2'd1;
  localparam logic [1:0] STAT_LONG  = 2'd2;

  // Command from the front to the back
  typedef struct packed {
    logic [1:0]       status;
    logic             bank;
    logic [CNT_W-1:0] len;
  } cmd_t;

  // Bank release from the back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

FILE: rtl/core/serial_frame_deframer_top.sv
// Serial frame deframer.
// Input channel: drive rx_byte_i with push; a byte is taken on a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result sits on frame_byte_o, status_o and last_of_run_o; pop takes it.
// A good frame comes out whole, one result per byte, last_of_run_o set on
// its final byte. A checksum error (status 1) or an overlong frame (status 2)
// gives one result with frame_byte_o zero and last_of_run_o set.
// A status result reaches the result ports through the command queue and the
// output register; a good frame's bytes pass the command queue, the drain state,
// the registered read of the frame store and the output register. One input
// byte per cycle is taken while full is low; a good frame drains one byte at a
// time: a store read waits until the byte before sits in the single output register.
// The store holds two frames, so a new frame fills while the last drains;
// full rises when both are pending or the two-entry command queue is full.
// A stalled receiver holds the output register and, behind it, the drain.
// Reset clears all control state; the block starts waiting for a start byte
// and needs no clearing pass.
module serial_frame_deframer_top import sdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte_o,
  output logic [1:0] status_o,
  output logic       last_of_run_o
);

  `include "assert_macros.svh"

  logic              cmd_full, cmd_empty, cmd_push, cmd_pop;
  cmd_t              cmd_in, cmd_out;
  rel_t              rel;
  logic              we, re;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  // Front: accept and classify bytes, fill the frame store
  sdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .rel_i      (rel),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata)
  );

  // Command queue between front and back
  sdf_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  // Frame store, two banks
  sdf_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Back: drain frames and emit results
  sdf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .rel_o         (rel),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .empty_o       (empty),
    .pop_i         (pop),
    .frame_byte_o  (frame_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  `ASSERT_ALWAYS(a_cmdq_no_overflow, !(cmd_push && cmd_full))
  `ASSERT_ALWAYS(a_cmdq_no_underflow, !(cmd_pop && cmd_empty))
  `ASSERT_IMPLY(a_status_shape, !empty && status_o != STAT_FRAME,
                last_of_run_o && frame_byte_o == 8'd0)
  `ASSERT_IMPLY(a_no_write_during_read_bank, we && re, waddr[RAM_AW-1] != raddr[RAM_AW-1])

endmodule

FILE: rtl/core/sdf_ram.sv
module sdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sdf_front.sv
module sdf_front import sdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        rx_byte_i,
  output logic              full_o,
  input  logic              cmd_full_i,
  output logic              cmd_push_o,
  output cmd_t              cmd_o,
  input  rel_t              rel_i,
  output logic              we_o,
  output logic [RAM_AW-1:0] waddr_o,
  output logic [7:0]        wdata_o
);

  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       prev_q, prev_d;
  logic             par_q, par_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic             acc;
  logic [IDX_W-1:0] widx;
  logic             par_new;
  logic [CNT_W-1:0] cnt_new;
  logic [7:0]       len_cur;
  logic [7:0]       expected;
  logic             window;

  // Stall while the command queue is full or the next bank still drains
  assign full_o = cmd_full_i || busy_q[bank_q];
  assign acc    = push_i && !full_o;

  // Per-byte values for a byte inside a frame
  assign widx     = count_q[IDX_W-1:0];
  assign par_new  = par_q ^ ((count_q >= CNT_W'(3)) ? rx_byte_i[0] : 1'b0);
  assign cnt_new  = count_q + CNT_W'(1);
  assign len_cur  = (count_q == CNT_W'(2)) ? rx_byte_i : len_q;
  assign expected = len_cur + LEN_EXTRA;
  assign window   = (cnt_new == CNT_W'(4)) ? 1'b0 : (par_new ^ prev_q[0] ^ 1'b1);

  // Classify the accepted byte
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    len_d      = len_q;
    prev_d     = prev_q;
    par_d      = par_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    we_o       = 1'b0;
    waddr_o    = {bank_q, widx};
    wdata_o    = rx_byte_i;
    cmd_push_o = 1'b0;
    cmd_o      = '{status: STAT_FRAME, bank: bank_q, len: cnt_new};

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (acc) begin
      if (!in_frame_q) begin
        if (rx_byte_i == START_BYTE) begin
          we_o       = 1'b1;
          waddr_o    = {bank_q, IDX_W'(0)};
          count_d    = CNT_W'(1);
          par_d      = 1'b0;
          prev_d     = rx_byte_i;
          in_frame_d = 1'b1;
        end
      end else if (CMP_W'(count_q) >= CMP_W'(MAX_FRAME)) begin
        cmd_push_o    = 1'b1;
        cmd_o.status  = STAT_LONG;
        in_frame_d    = 1'b0;
      end else begin
        we_o    = 1'b1;
        par_d   = par_new;
        count_d = cnt_new;
        prev_d  = rx_byte_i;
        len_d   = len_cur;
        if (rx_byte_i == END_BYTE && cnt_new >= CNT_W'(3)) begin
          if (CMP_W'(cnt_new) == CMP_W'(expected)) begin
            cmd_push_o = 1'b1;
            in_frame_d = 1'b0;
            if (cnt_new < CNT_W'(4) || prev_q != {7'd0, window}) begin
              cmd_o.status = STAT_CSUM;
            end else begin
              busy_d[bank_q] = 1'b1;
              bank_d         = !bank_q;
            end
          end else if (CMP_W'(expected) > CMP_W'(MAX_FRAME)) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = STAT_LONG;
            in_frame_d   = 1'b0;
          end
        end
      end
    end
  end

  // Frame tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      par_q      <= 1'b0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      par_q      <= par_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  // Length and previous byte are payload
  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    prev_q <= prev_d;
  end

endmodule

FILE: rtl/core/sdf_cmdq.sv
module sdf_cmdq import sdf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/core/sdf_back.sv
module sdf_back import sdf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output rel_t              rel_o,
  output logic              re_o,
  output logic [RAM_AW-1:0] raddr_o,
  input  logic [7:0]        rdata_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        frame_byte_o,
  output logic [1:0]        status_o,
  output logic              last_of_run_o
);

  logic             act_q, act_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             out_v_q, out_v_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic [1:0]       out_stat_q, out_stat_d;
  logic             out_last_q, out_last_d;

  logic             slot_free;
  logic             idx_last;

  // The output slot is free at the coming edge and no read is in flight
  assign slot_free = !pend_q && (!out_v_q || pop_i);
  assign idx_last  = (CNT_W'(idx_q) + CNT_W'(1) == len_q);
  assign raddr_o   = {bank_q, idx_q};

  // Drain frames from the store and emit status results
  always_comb begin
    act_d       = act_q;
    bank_d      = bank_q;
    len_d       = len_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    out_v_d     = out_v_q;
    out_byte_d  = out_byte_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    cmd_pop_o   = 1'b0;
    re_o        = 1'b0;
    rel_o       = '{valid: 1'b0, bank: bank_q};

    if (out_v_q && pop_i) begin
      out_v_d = 1'b0;
    end

    if (pend_q) begin
      out_v_d    = 1'b1;
      out_byte_d = rdata_i;
      out_stat_d = STAT_FRAME;
      out_last_d = pend_last_q;
    end else if (act_q) begin
      if (slot_free) begin
        re_o        = 1'b1;
        pend_d      = 1'b1;
        pend_last_d = idx_last;
        idx_d       = idx_q + IDX_W'(1);
        if (idx_last) begin
          act_d       = 1'b0;
          rel_o.valid = 1'b1;
        end
      end
    end else if (!cmd_empty_i) begin
      if (cmd_i.status != STAT_FRAME) begin
        if (slot_free) begin
          cmd_pop_o  = 1'b1;
          out_v_d    = 1'b1;
          out_byte_d = 8'd0;
          out_stat_d = cmd_i.status;
          out_last_d = 1'b1;
        end
      end else begin
        cmd_pop_o = 1'b1;
        act_d     = 1'b1;
        bank_d    = cmd_i.bank;
        len_d     = cmd_i.len;
        idx_d     = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    bank_q      <= bank_d;
    len_q       <= len_d;
    idx_q       <= idx_d;
    pend_last_q <= pend_last_d;
    out_byte_q  <= out_byte_d;
    out_stat_q  <= out_stat_d;
    out_last_q  <= out_last_d;
  end

  assign empty_o       = !out_v_q;
  assign frame_byte_o  = out_byte_q;
  assign status_o      = out_stat_q;
  assign last_of_run_o = out_last_q;

endmodule
